// File: sv/wfps_pkg.sv
`timescale 1ns / 1ps
// Shared types and constants of the two-beam wall-following steering block.
// No dependencies; imported by every module of the block.
package wfps_pkg;

  // Q16 trigonometric constants for the 57 degree beam and CORDIC gain
  localparam logic [19:0] Sin57Q16      = 20'd54963;
  localparam logic [19:0] Cos57Q16      = 20'd35694;
  localparam logic [19:0] CordicInvGain = 20'd39796;

  // error and integral saturation bounds
  localparam logic signed [63:0] ErrMax = 64'sd131071;
  localparam logic signed [63:0] ErrMin = -64'sd131072;
  localparam logic signed [39:0] IntegMax = {1'b0, {39{1'b1}}};
  localparam logic signed [39:0] IntegMin = {1'b1, {39{1'b0}}};

  // steering scale: total / 5120 as (|total| >> 10) / 5, the divide by five
  // done as a multiply by ceil(2^18 / 5) followed by a shift by 18
  localparam logic [19:0] Div5Recip = 20'd52429;

  // shared datapath widths
  localparam int MulAW  = 36;
  localparam int MulBW  = 20;
  localparam int DivDW  = 64;
  localparam int DivVW  = 36;

  // configuration register indexes
  typedef enum logic [3:0] {
    REG_DESIRED  = 4'd0,
    REG_GAIN_P   = 4'd1,
    REG_GAIN_D   = 4'd2,
    REG_GAIN_I   = 4'd3,
    REG_CRUISE   = 4'd4,
    REG_TURN     = 4'd5,
    REG_LIMIT    = 4'd6,
    REG_SLOW     = 4'd7
  } cfg_reg_e;

  // sequencer states
  typedef enum logic [17:0] {
    ST_IDLE  = 18'b000000000000000001,
    ST_MX    = 18'b000000000000000010,
    ST_MY    = 18'b000000000000000100,
    ST_CINIT = 18'b000000000000001000,
    ST_CORD  = 18'b000000000000010000,
    ST_RLO   = 18'b000000000000100000,
    ST_RHI   = 18'b000000000001000000,
    ST_RSUM  = 18'b000000000010000000,
    ST_NUM1  = 18'b000000000100000000,
    ST_NUM2  = 18'b000000001000000000,
    ST_DIVD  = 18'b000000010000000000,
    ST_P1    = 18'b000000100000000000,
    ST_P2    = 18'b000001000000000000,
    ST_P3    = 18'b000010000000000000,
    ST_P4    = 18'b000100000000000000,
    ST_P5    = 18'b001000000000000000,
    ST_DIVS  = 18'b010000000000000000,
    ST_FIN   = 18'b100000000000000000
  } state_e;

endpackage

// File: sv/wfps_mul.sv
`timescale 1ns / 1ps
// Shared signed multiplier with a registered product.
// Depends on wfps_pkg for operand widths.
module wfps_mul (
  input  logic                                  clk_i,
  input  logic signed [wfps_pkg::MulAW-1:0]     op_a_i,
  input  logic signed [wfps_pkg::MulBW-1:0]     op_b_i,
  output logic signed [wfps_pkg::MulAW+wfps_pkg::MulBW-1:0] prod_o
);
  import wfps_pkg::*;

  logic signed [MulAW+MulBW-1:0] prod_q;

  // register every product
  always_ff @(posedge clk_i) begin
    prod_q <= op_a_i * op_b_i;
  end

  assign prod_o = prod_q;

endmodule

// File: sv/wfps_div.sv
`timescale 1ns / 1ps
// Radix-2 restoring unsigned divider, one quotient bit per cycle.
// Depends on wfps_pkg for default widths.
module wfps_div #(
  parameter int DW = 64,
  parameter int VW = 36
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          start_i,
  input  logic [DW-1:0] dividend_i,
  input  logic [VW-1:0] divisor_i,
  output logic          done_o,
  output logic [DW-1:0] quot_o
);
  import wfps_pkg::*;

  localparam int CW = $clog2(DW);

  logic          busy_q, busy_d;
  logic          done_q, done_d;
  logic [CW-1:0] cnt_q, cnt_d;
  logic [VW-1:0] rem_q, rem_d;
  logic [VW-1:0] div_q, div_d;
  logic [DW-1:0] quot_q, quot_d;
  logic [VW:0]   shifted;
  logic [VW:0]   trial;

  // one restoring step: shift in next dividend bit, subtract if it fits
  always_comb begin
    busy_d  = busy_q;
    done_d  = 1'b0;
    cnt_d   = cnt_q;
    rem_d   = rem_q;
    div_d   = div_q;
    quot_d  = quot_q;
    shifted = {rem_q, quot_q[DW-1]};
    trial   = shifted - {1'b0, div_q};
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = '0;
      rem_d  = '0;
      div_d  = divisor_i;
      quot_d = dividend_i;
    end else if (busy_q) begin
      if (!trial[VW]) begin
        rem_d  = trial[VW-1:0];
        quot_d = {quot_q[DW-2:0], 1'b1};
      end else begin
        rem_d  = shifted[VW-1:0];
        quot_d = {quot_q[DW-2:0], 1'b0};
      end
      cnt_d = cnt_q + 1'b1;
      if (cnt_q == CW'(DW - 1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q  <= rem_d;
    div_q  <= div_d;
    quot_q <= quot_d;
  end

  assign done_o = done_q;
  assign quot_o = quot_q;

endmodule

// File: sv/wall_follow_pid_steering.sv
`timescale 1ns / 1ps
// Two-beam wall-following PID steering. One scan transaction (square and ahead
// ranges) runs, from acceptance until the input is ready again, through a
// CORDIC vectoring run of one shift-add step per cycle, a handful of passes
// through one shared 36x20 multiplier (the steering scale included, as a
// reciprocal multiply), and one run of the shared radix-2 divider for the
// projection, which dominates. A scan with a zero range skips the geometry.
// The input is not ready while a scan is in work; a finished result waits in
// the output register while the next scan is taken, and a scan that finishes
// before that result is taken holds in its last state.
// Depends on wfps_pkg, wfps_mul and wfps_div.
module wall_follow_pid_steering #(
  parameter int LOOKAHEAD_MM = 1000,
  parameter int CORDIC_STEPS = 16
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic [15:0]        range_square_i,
  input  logic [15:0]        range_ahead_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic signed [11:0] steering_mrad_o,
  output logic [15:0]        speed_mm_s_o,
  output logic signed [17:0] error_mm_o,
  output logic               held_error_o,
  input  logic               cfg_valid_i,
  output logic               cfg_ready_o,
  input  logic [3:0]         cfg_index_i,
  input  logic [15:0]        cfg_data_i
);
  import wfps_pkg::*;

  localparam int CW = (CORDIC_STEPS > 1) ? $clog2(CORDIC_STEPS) : 1;

  // configuration registers
  logic [15:0] desired_q, gain_p_q, gain_d_q, gain_i_q, cruise_q, turn_q;
  logic [10:0] limit_q, slow_q;

  // sequencer and datapath registers
  state_e                state_q, state_d;
  logic [15:0]           b_q, b_d, a_q, a_d;
  logic signed [35:0]    x_q, x_d, y_q, y_d, cx_q, cx_d, cy_q, cy_d;
  logic [35:0]           r_q, r_d;
  logic signed [63:0]    acc_q, acc_d;
  logic                  neg_q, neg_d;
  logic [CW-1:0]         cnt_q, cnt_d;
  logic signed [17:0]    e_q, e_d;
  logic                  held_q, held_d;
  logic signed [18:0]    diff_q, diff_d;
  logic signed [39:0]    newint_q, newint_d;
  logic [10:0]           mag_q, mag_d;
  logic signed [17:0]    last_err_q, last_err_d;
  logic signed [39:0]    integ_q, integ_d;

  // output registers
  logic                  out_valid_q, out_valid_d;
  logic signed [11:0]    steer_q, steer_d;
  logic [15:0]           speed_q, speed_d;
  logic signed [17:0]    err_out_q, err_out_d;
  logic                  held_out_q, held_out_d;

  // shared units
  logic signed [MulAW-1:0]       mul_a;
  logic signed [MulBW-1:0]       mul_b;
  logic signed [MulAW+MulBW-1:0] prod;
  logic signed [63:0]            prod64;
  logic                          div_start;
  logic [DivDW-1:0]              div_dvd;
  logic [DivVW-1:0]              div_dvs;
  logic                          div_done;
  logic [DivDW-1:0]              div_quot;

  // scratch
  logic signed [35:0] sx, sy;
  logic signed [63:0] sum64, dval, eh;
  logic signed [40:0] isum;
  logic [63:0]        tmag;
  logic [13:0]        lim5;

  wfps_mul u_mul (
    .clk_i  (clk_i),
    .op_a_i (mul_a),
    .op_b_i (mul_b),
    .prod_o (prod)
  );

  wfps_div #(
    .DW (DivDW),
    .VW (DivVW)
  ) u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (div_dvd),
    .divisor_i  (div_dvs),
    .done_o     (div_done),
    .quot_o     (div_quot)
  );

  assign prod64 = {{(64-MulAW-MulBW){prod[MulAW+MulBW-1]}}, prod};

  // sequence one scan through the shared units
  always_comb begin
    state_d     = state_q;
    b_d         = b_q;
    a_d         = a_q;
    x_d         = x_q;
    y_d         = y_q;
    cx_d        = cx_q;
    cy_d        = cy_q;
    r_d         = r_q;
    acc_d       = acc_q;
    neg_d       = neg_q;
    cnt_d       = cnt_q;
    e_d         = e_q;
    held_d      = held_q;
    diff_d      = diff_q;
    newint_d    = newint_q;
    mag_d       = mag_q;
    last_err_d  = last_err_q;
    integ_d     = integ_q;
    out_valid_d = out_valid_q;
    steer_d     = steer_q;
    speed_d     = speed_q;
    err_out_d   = err_out_q;
    held_out_d  = held_out_q;
    mul_a       = '0;
    mul_b       = '0;
    div_start   = 1'b0;
    div_dvd     = '0;
    div_dvs     = '0;
    sx          = cx_q >>> cnt_q;
    sy          = cy_q >>> cnt_q;
    sum64       = '0;
    dval        = '0;
    eh          = '0;
    isum        = '0;
    tmag        = '0;
    lim5        = '0;

    // drop the result once taken
    if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end

    case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          b_d = range_square_i;
          a_d = range_ahead_i;
          if (range_square_i == 16'd0 || range_ahead_i == 16'd0) begin
            e_d     = last_err_q;
            held_d  = 1'b1;
            state_d = ST_P1;
          end else begin
            held_d  = 1'b0;
            state_d = ST_MX;
          end
        end
      end
      ST_MX: begin
        mul_a   = {20'd0, a_q};
        mul_b   = Sin57Q16;
        state_d = ST_MY;
      end
      ST_MY: begin
        x_d     = prod[35:0];
        mul_a   = {20'd0, a_q};
        mul_b   = Cos57Q16;
        state_d = ST_CINIT;
      end
      ST_CINIT: begin
        y_d     = prod[35:0] - $signed({4'd0, b_q, 16'd0});
        cx_d    = x_q;
        cy_d    = prod[35:0] - $signed({4'd0, b_q, 16'd0});
        cnt_d   = '0;
        state_d = ST_CORD;
      end
      ST_CORD: begin
        // rotate the vector toward the x axis
        if (cy_q[35]) begin
          cx_d = cx_q - sy;
          cy_d = cy_q + sx;
        end else begin
          cx_d = cx_q + sy;
          cy_d = cy_q - sx;
        end
        cnt_d = cnt_q + 1'b1;
        if (cnt_q == CW'(CORDIC_STEPS - 1)) begin
          state_d = ST_RLO;
        end
      end
      ST_RLO: begin
        mul_a   = {18'd0, cx_q[17:0]};
        mul_b   = CordicInvGain;
        state_d = ST_RHI;
      end
      ST_RHI: begin
        acc_d   = prod64;
        mul_a   = {{18{cx_q[35]}}, cx_q[35:18]};
        mul_b   = CordicInvGain;
        state_d = ST_RSUM;
      end
      ST_RSUM: begin
        // gain-corrected magnitude, at least one
        sum64 = (acc_q + (prod64 <<< 18)) >>> 16;
        if (sum64 < 64'sd1) begin
          r_d = 36'd1;
        end else begin
          r_d = sum64[35:0];
        end
        mul_a   = x_q;
        mul_b   = {4'd0, b_q};
        state_d = ST_NUM1;
      end
      ST_NUM1: begin
        acc_d   = prod64;
        mul_a   = y_q;
        mul_b   = MulBW'(LOOKAHEAD_MM);
        state_d = ST_NUM2;
      end
      ST_NUM2: begin
        sum64     = acc_q + prod64;
        neg_d     = sum64[63];
        div_start = 1'b1;
        div_dvd   = sum64[63] ? 64'(-sum64) : 64'(sum64);
        div_dvs   = r_q;
        state_d   = ST_DIVD;
      end
      ST_DIVD: begin
        if (div_done) begin
          dval = neg_q ? -$signed(div_quot) : $signed(div_quot);
          eh   = $signed({48'd0, desired_q}) - dval;
          if (eh > ErrMax) begin
            e_d = 18'sh1FFFF;
          end else if (eh < ErrMin) begin
            e_d = 18'sh20000;
          end else begin
            e_d = eh[17:0];
          end
          state_d = ST_P1;
        end
      end
      ST_P1: begin
        diff_d = {e_q[17], e_q} - {last_err_q[17], last_err_q};
        isum   = {integ_q[39], integ_q} + {{23{e_q[17]}}, e_q};
        if (isum[40] != isum[39]) begin
          newint_d = isum[40] ? IntegMin : IntegMax;
        end else begin
          newint_d = isum[39:0];
        end
        mul_a   = {{18{e_q[17]}}, e_q};
        mul_b   = {4'd0, gain_p_q};
        state_d = ST_P2;
      end
      ST_P2: begin
        acc_d   = (prod64 <<< 4) + (prod64 <<< 2);
        mul_a   = {{17{diff_q[18]}}, diff_q};
        mul_b   = {4'd0, gain_d_q};
        state_d = ST_P3;
      end
      ST_P3: begin
        acc_d   = acc_q + (prod64 <<< 8) + (prod64 <<< 7) + (prod64 <<< 4);
        mul_a   = {16'd0, newint_q[19:0]};
        mul_b   = {4'd0, gain_i_q};
        state_d = ST_P4;
      end
      ST_P4: begin
        acc_d   = acc_q + prod64;
        mul_a   = {{16{newint_q[39]}}, newint_q[39:20]};
        mul_b   = {4'd0, gain_i_q};
        state_d = ST_P5;
      end
      ST_P5: begin
        // scale the magnitude by 1/5120; past the limit, feed five times the limit
        sum64 = acc_q + (prod64 <<< 20);
        neg_d = sum64[63];
        tmag  = sum64[63] ? 64'(-sum64) : 64'(sum64);
        lim5  = {1'b0, limit_q, 2'b00} + {3'd0, limit_q};
        if (tmag[63:10] >= {40'd0, lim5 + 14'd5}) begin
          mul_a = {22'd0, lim5};
        end else begin
          mul_a = {22'd0, tmag[23:10]};
        end
        mul_b   = Div5Recip;
        state_d = ST_DIVS;
      end
      ST_DIVS: begin
        // take the clamped steering magnitude
        mag_d   = prod[28:18];
        state_d = ST_FIN;
      end
      ST_FIN: begin
        if (!out_valid_q || out_ready_i) begin
          out_valid_d = 1'b1;
          steer_d     = neg_q ? -$signed({1'b0, mag_q}) : $signed({1'b0, mag_q});
          speed_d     = (mag_q > slow_q) ? turn_q : cruise_q;
          err_out_d   = e_q;
          held_out_d  = held_q;
          last_err_d  = e_q;
          integ_d     = newint_q;
          state_d     = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // control state and PID history
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
      last_err_q  <= '0;
      integ_q     <= '0;
      cnt_q       <= '0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
      last_err_q  <= last_err_d;
      integ_q     <= integ_d;
      cnt_q       <= cnt_d;
    end
  end

  // datapath payload
  always_ff @(posedge clk_i) begin
    b_q        <= b_d;
    a_q        <= a_d;
    x_q        <= x_d;
    y_q        <= y_d;
    cx_q       <= cx_d;
    cy_q       <= cy_d;
    r_q        <= r_d;
    acc_q      <= acc_d;
    neg_q      <= neg_d;
    e_q        <= e_d;
    held_q     <= held_d;
    diff_q     <= diff_d;
    newint_q   <= newint_d;
    mag_q      <= mag_d;
    steer_q    <= steer_d;
    speed_q    <= speed_d;
    err_out_q  <= err_out_d;
    held_out_q <= held_out_d;
  end

  // configuration writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      desired_q <= 16'd1000;
      gain_p_q  <= 16'd384;
      gain_d_q  <= 16'd307;
      gain_i_q  <= 16'd0;
      cruise_q  <= 16'd5000;
      turn_q    <= 16'd3000;
      limit_q   <= 11'd400;
      slow_q    <= 11'd170;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        REG_DESIRED: desired_q <= cfg_data_i;
        REG_GAIN_P:  gain_p_q  <= cfg_data_i;
        REG_GAIN_D:  gain_d_q  <= cfg_data_i;
        REG_GAIN_I:  gain_i_q  <= cfg_data_i;
        REG_CRUISE:  cruise_q  <= cfg_data_i;
        REG_TURN:    turn_q    <= cfg_data_i;
        REG_LIMIT:   limit_q   <= cfg_data_i[10:0];
        REG_SLOW:    slow_q    <= cfg_data_i[10:0];
        default: begin
        end
      endcase
    end
  end

  assign cfg_ready_o     = 1'b1;
  assign in_ready_o      = (state_q == ST_IDLE);
  assign out_valid_o     = out_valid_q;
  assign steering_mrad_o = steer_q;
  assign speed_mm_s_o    = speed_q;
  assign error_mm_o      = err_out_q;
  assign held_error_o    = held_out_q;

endmodule

// File: tb/wall_follow_pid_steering_test.sv
`timescale 1ns / 1ps
// Testbench for wall_follow_pid_steering: a scoreboard class predicts each steering
// command from the accepted ranges, and plain tasks drive scans and register writes.
// Depends on wfps_pkg and the wall_follow_pid_steering RTL.
module wall_follow_pid_steering_test;
  import wfps_pkg::*;

  localparam int LookaheadMm = 1000;
  localparam int CordicSteps = 16;
  localparam logic [3:0] UnusedRegIdx = 4'd11;

  // Predicts steering commands and holds the ones not yet seen at the output
  class steer_scoreboard;
    typedef struct {
      logic signed [11:0] steer;
      logic [15:0]        speed;
      logic signed [17:0] err;
      logic               held;
    } steer_cmd_t;

    longint     desired, kp, kd, ki, cruise, turn, limit, slow;
    longint     last_err, err_sum;
    steer_cmd_t cmd_q[$];

    function new();
      desired = 1000; kp = 384; kd = 307; ki = 0;
      cruise = 5000; turn = 3000; limit = 400; slow = 170;
      last_err = 0; err_sum = 0;
    endfunction

    function void write_reg(logic [3:0] idx, logic [15:0] val);
      case (idx)
        REG_DESIRED: desired = val;
        REG_GAIN_P:  kp = val;
        REG_GAIN_D:  kd = val;
        REG_GAIN_I:  ki = val;
        REG_CRUISE:  cruise = val;
        REG_TURN:    turn = val;
        REG_LIMIT:   limit = val[10:0];
        REG_SLOW:    slow = val[10:0];
        default: ;
      endcase
    endfunction

    // wall distance one lookahead ahead, via CORDIC magnitude of (x, y)
    function longint wall_proj_mm(longint a, longint b);
      longint x, y, cx, cy, sx, sy, r;
      x = a * 54963;
      y = a * 35694 - b * 65536;
      cx = x;
      cy = y;
      for (int i = 0; i < CordicSteps; i++) begin
        sx = cx >>> i;
        sy = cy >>> i;
        if (cy < 0) begin
          cx = cx - sy; cy = cy + sx;
        end else begin
          cx = cx + sy; cy = cy - sx;
        end
      end
      r = (cx * 39796) >>> 16;
      if (r < 1) r = 1;
      return (b * x + LookaheadMm * y) / r;
    endfunction

    function void note_scan(logic [15:0] sq, logic [15:0] ah);
      longint e, diff, total, steer, mag;
      steer_cmd_t c;
      c.held = (sq == 0 || ah == 0);
      if (c.held) begin
        e = last_err;
      end else begin
        e = desired - wall_proj_mm(ah, sq);
        if (e > 131071) e = 131071;
        if (e < -131072) e = -131072;
      end
      diff = e - last_err;
      err_sum = err_sum + e;
      if (err_sum > 64'sd549755813887) err_sum = 64'sd549755813887;
      if (err_sum < -64'sd549755813888) err_sum = -64'sd549755813888;
      total = 20 * kp * e + 400 * kd * diff + ki * err_sum;
      steer = total / 5120;
      if (steer > limit) steer = limit;
      if (steer < -limit) steer = -limit;
      mag = steer < 0 ? -steer : steer;
      c.steer = steer[11:0];
      c.speed = (mag > slow) ? turn[15:0] : cruise[15:0];
      c.err = e[17:0];
      last_err = e;
      cmd_q.push_back(c);
    endfunction

    // empty string when the command matches the oldest prediction
    function string check_cmd(logic signed [11:0] st, logic [15:0] sp,
                              logic signed [17:0] er, logic hd);
      steer_cmd_t c;
      string msg;
      if (cmd_q.size() == 0) return "steering command with no scan pending";
      c = cmd_q.pop_front();
      msg = "";
      if (st !== c.steer) msg = {msg, $sformatf(" steer %0d/%0d", st, c.steer)};
      if (sp !== c.speed) msg = {msg, $sformatf(" speed %0d/%0d", sp, c.speed)};
      if (er !== c.err) msg = {msg, $sformatf(" error %0d/%0d", er, c.err)};
      if (hd !== c.held) msg = {msg, $sformatf(" held %0b/%0b", hd, c.held)};
      return msg;
    endfunction

    function int pending();
      return cmd_q.size();
    endfunction
  endclass

  logic               clk_i, rst_ni;
  logic               in_valid, in_ready;
  logic [15:0]        range_square, range_ahead;
  logic               out_valid, out_ready;
  logic signed [11:0] steering_mrad;
  logic [15:0]        speed_mm_s;
  logic signed [17:0] error_mm;
  logic               held_error;
  logic               cfg_valid, cfg_ready;
  logic [3:0]         cfg_index;
  logic [15:0]        cfg_data;

  steer_scoreboard sb = new();
  int  mismatches = 0;
  bit  idle_on = 1;
  int  stall_left = 0;

  wall_follow_pid_steering #(
    .LOOKAHEAD_MM(LookaheadMm),
    .CORDIC_STEPS(CordicSteps)
  ) dut (
    .clk_i(clk_i), .rst_ni(rst_ni),
    .in_valid_i(in_valid), .in_ready_o(in_ready),
    .range_square_i(range_square), .range_ahead_i(range_ahead),
    .out_valid_o(out_valid), .out_ready_i(out_ready),
    .steering_mrad_o(steering_mrad), .speed_mm_s_o(speed_mm_s),
    .error_mm_o(error_mm), .held_error_o(held_error),
    .cfg_valid_i(cfg_valid), .cfg_ready_o(cfg_ready),
    .cfg_index_i(cfg_index), .cfg_data_i(cfg_data)
  );

  initial begin
    clk_i = 0;
    forever #5 clk_i = ~clk_i;
  end

  task automatic report_mismatch(string msg);
    mismatches++;
    $display("[%0t] mismatch:%s", $time, msg);
  endtask

  // Accept results and stall the output in random bursts
  always @(posedge clk_i) begin
    string msg;
    if (rst_ni && out_valid && out_ready) begin
      msg = sb.check_cmd(steering_mrad, speed_mm_s, error_mm, held_error);
      if (msg != "") report_mismatch(msg);
    end
    if (stall_left > 0) begin
      out_ready <= 1'b0;
      stall_left--;
    end else begin
      out_ready <= 1'b1;
      if (idle_on && $urandom_range(0, 7) == 0) stall_left = $urandom_range(1, 13);
    end
  end

  task automatic send_scan(logic [15:0] sq, logic [15:0] ah);
    if (idle_on && $urandom_range(0, 3) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 13)) @(posedge clk_i);
    end
    in_valid <= 1'b1;
    range_square <= sq;
    range_ahead <= ah;
    do @(posedge clk_i); while (!in_ready);
    sb.note_scan(sq, ah);
  endtask

  // Hold until every predicted command has come out
  task automatic drain();
    in_valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk_i);
    @(posedge clk_i);
  endtask

  task automatic write_reg(logic [3:0] idx, logic [15:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    do @(posedge clk_i); while (!cfg_ready);
    sb.write_reg(idx, val);
    cfg_valid <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic write_all(logic [15:0] des, logic [15:0] p, logic [15:0] d,
                           logic [15:0] i, logic [15:0] cr, logic [15:0] tu,
                           logic [15:0] lim, logic [15:0] sl);
    write_reg(REG_DESIRED, des);
    write_reg(REG_GAIN_P, p);
    write_reg(REG_GAIN_D, d);
    write_reg(REG_GAIN_I, i);
    write_reg(REG_CRUISE, cr);
    write_reg(REG_TURN, tu);
    write_reg(REG_LIMIT, lim);
    write_reg(REG_SLOW, sl);
  endtask

  // Mostly plausible wall geometry, with dropouts and raw noise mixed in
  task automatic random_scan();
    int kind;
    logic [15:0] b, a;
    kind = int'($urandom_range(0, 19));
    b = 16'($urandom_range(150, 6000));
    a = 16'(b * 2 - 160 + $urandom_range(0, 600));
    if (kind == 0) b = 0;
    else if (kind == 1) a = 0;
    else if (kind < 4) begin
      b = 16'($urandom);
      a = 16'($urandom);
    end
    send_scan(b, a);
  endtask

  initial begin
    in_valid = 0; range_square = 0; range_ahead = 0;
    out_ready = 0; cfg_valid = 0; cfg_index = REG_DESIRED; cfg_data = 0;
    rst_ni = 0;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: range extremes and dropouts at reset settings
    send_scan(16'd1000, 16'd1836);
    send_scan(16'd0, 16'd1836);
    send_scan(16'd1200, 16'd0);
    send_scan(16'd0, 16'd0);
    send_scan(16'd1, 16'd1);
    send_scan(16'hFFFF, 16'hFFFF);
    send_scan(16'd1, 16'hFFFF);
    send_scan(16'hFFFF, 16'd1);
    send_scan(16'd400, 16'd3000);
    send_scan(16'd3000, 16'd400);
    drain();

    // full gains, wide limit with masked upper bits, zero threshold, far target
    write_all(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'd0,
              16'hFFFF, 16'hF800);
    write_reg(UnusedRegIdx, 16'h1234);
    send_scan(16'd1000, 16'd1836);
    send_scan(16'd0, 16'd500);
    send_scan(16'd1, 16'hFFFF);
    send_scan(16'hFFFF, 16'd1);
    send_scan(16'd2000, 16'd2000);
    drain();

    // everything at zero but the turn speed
    write_all(16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 16'hFFFF, 16'd0, 16'd0);
    send_scan(16'd1000, 16'd1836);
    send_scan(16'd50, 16'd8000);
    send_scan(16'd8000, 16'd0);
    drain();

    // random phases, each under its own settings; the last runs without idling
    for (int ph = 0; ph < 10; ph++) begin
      if (ph == 9) idle_on = 0;
      if (ph % 3 == 2) begin
        write_all(16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom),
                  16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom));
      end else begin
        write_all(16'($urandom_range(300, 3000)), 16'($urandom_range(0, 2000)),
                  16'($urandom_range(0, 1500)), 16'($urandom_range(0, 40)),
                  16'($urandom_range(0, 9000)), 16'($urandom_range(0, 9000)),
                  16'($urandom_range(0, 1571)), 16'($urandom_range(0, 1571)));
      end
      for (int n = 0; n < 123; n++) random_scan();
      drain();
    end

    repeat (200) @(posedge clk_i);
    if (sb.pending() != 0) report_mismatch("predicted commands never came out");
    if (mismatches == 0) begin
      $display("** wall_follow_pid_steering: PASSED **");
    end else begin
      $display("** wall_follow_pid_steering: FAILED **");
    end
    $finish;
  end

  initial begin
    #20_000_000;
    $display("** wall_follow_pid_steering: FAILED **");
    $finish;
  end

endmodule
